// File: hdl/chpf_pkg.sv
`default_nettype none

package chpf_pkg;

	// Operation codes
	localparam logic [2:0] OP_WRITE_PLANE = 3'd0;
	localparam logic [2:0] OP_SET_COUNT   = 3'd1;
	localparam logic [2:0] OP_WRITE_POSE  = 3'd2;
	localparam logic [2:0] OP_APPLY_POSE  = 3'd3;
	localparam logic [2:0] OP_TEST_POINT  = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_ACTIVE_LINKS = 2'd0;
	localparam logic [1:0] REG_HULL_PADDING = 2'd1;

	localparam logic [30:0] PAD_RESET = 31'd655;

	typedef struct packed {
		logic [2:0]         operation;
		logic [4:0]         link_index;
		logic [6:0]         plane_index;
		logic [7:0]         plane_count;
		logic [1:0]         pose_row;
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
		logic signed [31:0] comp_w;
	} in_item_t;

	typedef struct packed {
		logic       point_inside;
		logic [4:0] matched_link;
	} out_item_t;

	// One plane or one pose row: four Q16.16 words, index 0 is x
	typedef logic [3:0][31:0] quad_t;

endpackage

`default_nettype wire

// File: hdl/convex_hull_point_filter_top.sv
`default_nettype none

// Convex hull point filter. Hull planes are written per link (offset padded on write),
// a pose is written per link in three rows, and an apply operation transforms the
// link's planes into posed planes. A test operation walks links from 0 and reports
// whether the point lies inside a hull and the first such link. Plane, count and pose
// writes complete without leaving the idle state. All multiplications go through one
// 32x32 multiplier and one accumulator under the sequencer: an apply loads the three
// pose rows, then for each plane reads it and runs 12 multiply-accumulate steps and 4
// rounding steps; a point test visits links in turn and, for each plane evaluated,
// reads it, runs 3 multiply-accumulate steps and compares. Input is not ready while an
// apply or test runs; a result waits in an output register while the next transaction
// is taken.
module convex_hull_point_filter_top
	import chpf_pkg::*;
#(
	parameter int MAX_LINKS  = 32,
	parameter int MAX_PLANES = 128,
	parameter int COORD_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire in_item_t  item,
	output logic           result_valid,
	input  wire logic      result_ready,
	output out_item_t      result,
	input  wire logic      cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [30:0] cfg_data
);

	localparam int LW    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int LCW   = $clog2(MAX_LINKS + 1);
	localparam int PW    = $clog2(MAX_PLANES);
	localparam int CW    = $clog2(MAX_PLANES + 1);
	localparam int DEPTH = MAX_LINKS * MAX_PLANES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PDEPTH = MAX_LINKS * 3;
	localparam int PAW   = $clog2(PDEPTH);
	localparam int CB    = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int ACW   = 68;
	localparam logic signed [ACW-1:0] SAT_HI = (ACW'(1) <<< (CB - 1)) - ACW'(1);
	localparam logic signed [ACW-1:0] SAT_LO = -SAT_HI - ACW'(1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PRD   = 4'd1;
	localparam logic [3:0] S_PWT   = 4'd2;
	localparam logic [3:0] S_LINK  = 4'd3;
	localparam logic [3:0] S_PLANE = 4'd4;
	localparam logic [3:0] S_WAIT  = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_ACC   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;

	function automatic logic signed [31:0] sat_word(input logic signed [ACW-1:0] v);
		logic signed [ACW-1:0] r;
		r = v;
		if (v > SAT_HI) r = SAT_HI;
		if (v < SAT_LO) r = SAT_LO;
		return r[31:0];
	endfunction

	logic [3:0]  state_q;
	logic        is_test_q;
	logic [LCW-1:0] link_q, lim_q;
	logic [CW-1:0]  plane_q, cnt_q;
	logic [1:0]  k_q, j_q, row_q;
	logic signed [31:0] pose_q [3][4];
	logic signed [31:0] pt_q [3];
	logic signed [31:0] res_q [3];
	logic signed [ACW-1:0] acc_q;
	logic signed [63:0] prod_q;
	logic [5:0]  active_q;
	logic [30:0] pad_q;
	logic [CW-1:0] counts_q [MAX_LINKS];
	logic        inside_q;
	logic [4:0]  match_q;
	logic        result_valid_q;
	out_item_t   result_q;

	quad_t raw_mem   [DEPTH];
	quad_t posed_mem [DEPTH];
	quad_t pose_mem  [PDEPTH];
	quad_t raw_rd_q, posed_rd_q, pose_rd_q;

	logic item_acc;
	logic [LW-1:0] lk_in;
	logic link_ok, plane_ok;
	logic signed [31:0] cin [4];
	logic signed [31:0] pad_w;
	logic [CW-1:0] cnt_rd, cnt_in;
	logic [AW-1:0] plane_addr, wr_addr;
	logic [PAW-1:0] pose_addr, pose_waddr;
	logic raw_we, posed_we, pose_we, counts_we, plane_re, pose_re;
	logic signed [31:0] mul_a, mul_b, hv;
	logic [LW-1:0] cnt_sel;

	assign item_ready   = (state_q == S_IDLE);
	assign item_acc     = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Decode and saturate the incoming transaction
	always_comb begin
		lk_in    = LW'(item.link_index);
		link_ok  = 32'(item.link_index) < 32'(MAX_LINKS);
		plane_ok = 32'(item.plane_index) < 32'(MAX_PLANES);
		cin[0]   = sat_word(ACW'(item.comp_x));
		cin[1]   = sat_word(ACW'(item.comp_y));
		cin[2]   = sat_word(ACW'(item.comp_z));
		cin[3]   = sat_word(ACW'(item.comp_w));
		pad_w    = sat_word(ACW'(cin[3]) - ACW'(pad_q));
		cnt_in   = (32'(item.plane_count) > 32'(MAX_PLANES)) ? CW'(MAX_PLANES)
			: CW'(item.plane_count);
		wr_addr  = AW'(32'(lk_in) * MAX_PLANES + 32'(item.plane_index));
		pose_waddr = PAW'(32'(lk_in) * 3 + 32'(item.pose_row));
		plane_addr = AW'(32'(link_q[LW-1:0]) * MAX_PLANES + 32'(plane_q[PW-1:0]));
		pose_addr  = PAW'(32'(link_q[LW-1:0]) * 3 + 32'(row_q));
		cnt_sel  = (state_q == S_IDLE) ? lk_in : link_q[LW-1:0];
		cnt_rd   = counts_q[cnt_sel];
		raw_we   = item_acc && (item.operation == OP_WRITE_PLANE) && link_ok && plane_ok;
		counts_we = item_acc && (item.operation == OP_SET_COUNT) && link_ok;
		pose_we  = item_acc && (item.operation == OP_WRITE_POSE) && link_ok
			&& (item.pose_row != 2'd3);
		plane_re = (state_q == S_PLANE) && (plane_q != cnt_q);
		pose_re  = (state_q == S_PRD);
		hv       = sat_word(acc_q >>> 16);
		posed_we = (state_q == S_FIN) && !is_test_q && (j_q == 2'd3);
		mul_a    = is_test_q ? $signed(posed_rd_q[k_q]) : $signed(raw_rd_q[k_q]);
		mul_b    = is_test_q ? pt_q[k_q] : pose_q[k_q][j_q];
	end

	// Plane and pose memories
	always_ff @(posedge clk) begin
		if (raw_we) raw_mem[wr_addr] <= {pad_w, cin[2], cin[1], cin[0]};
		if (plane_re) raw_rd_q <= raw_mem[plane_addr];
	end

	always_ff @(posedge clk) begin
		if (posed_we) posed_mem[plane_addr] <= {hv, res_q[2], res_q[1], res_q[0]};
		if (plane_re) posed_rd_q <= posed_mem[plane_addr];
	end

	always_ff @(posedge clk) begin
		if (pose_we) pose_mem[pose_waddr] <= {cin[3], cin[2], cin[1], cin[0]};
		if (pose_re) pose_rd_q <= pose_mem[pose_addr];
	end

	// Plane counts and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LINKS; i++) counts_q[i] <= '0;
			active_q <= '0;
			pad_q    <= PAD_RESET;
		end else begin
			if (counts_we) counts_q[lk_in] <= cnt_in;
			if (cfg_we) begin
				case (cfg_addr)
					REG_ACTIVE_LINKS: active_q <= cfg_data[5:0];
					REG_HULL_PADDING: pad_q    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			is_test_q <= 1'b0;
			link_q    <= '0;
			lim_q     <= '0;
			plane_q   <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			j_q       <= '0;
			row_q     <= '0;
			inside_q  <= 1'b0;
			match_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_acc && item.operation == OP_APPLY_POSE && link_ok) begin
						is_test_q <= 1'b0;
						link_q    <= LCW'(item.link_index);
						cnt_q     <= cnt_rd;
						plane_q   <= '0;
						row_q     <= '0;
						state_q   <= S_PRD;
					end else if (item_acc && item.operation == OP_TEST_POINT) begin
						is_test_q <= 1'b1;
						link_q    <= '0;
						lim_q     <= (32'(active_q) > 32'(MAX_LINKS)) ? LCW'(MAX_LINKS)
							: LCW'(active_q);
						state_q   <= S_LINK;
					end
				end
				S_PRD: state_q <= S_PWT;
				S_PWT: begin
					row_q   <= row_q + 2'd1;
					state_q <= (row_q == 2'd2) ? S_PLANE : S_PRD;
				end
				S_LINK: begin
					if (link_q == lim_q) begin
						inside_q <= 1'b0;
						match_q  <= '0;
						state_q  <= S_EMIT;
					end else if (cnt_rd == '0) begin
						link_q <= link_q + LCW'(1);
					end else begin
						cnt_q   <= cnt_rd;
						plane_q <= '0;
						state_q <= S_PLANE;
					end
				end
				S_PLANE: state_q <= (plane_q == cnt_q) ? S_IDLE : S_WAIT;
				S_WAIT: begin
					j_q     <= '0;
					k_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? S_FIN : S_MUL;
				end
				S_FIN: begin
					k_q <= '0;
					if (is_test_q) begin
						if (acc_q > 0) begin
							link_q  <= link_q + LCW'(1);
							state_q <= S_LINK;
						end else if (plane_q + CW'(1) == cnt_q) begin
							inside_q <= 1'b1;
							match_q  <= 5'(link_q);
							state_q  <= S_EMIT;
						end else begin
							plane_q <= plane_q + CW'(1);
							state_q <= S_PLANE;
						end
					end else if (j_q == 2'd3) begin
						plane_q <= plane_q + CW'(1);
						state_q <= S_PLANE;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_EMIT: begin
					if (!result_valid_q || result_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Shared multiplier, accumulator and working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_acc && item.operation == OP_TEST_POINT) begin
			for (int i = 0; i < 3; i++) pt_q[i] <= cin[i];
		end
		if (state_q == S_PWT) begin
			for (int i = 0; i < 4; i++) pose_q[row_q][i] <= $signed(pose_rd_q[i]);
		end
		if (state_q == S_WAIT) begin
			acc_q <= is_test_q ? (ACW'($signed(posed_rd_q[3])) <<< 16) : '0;
		end
		if (state_q == S_MUL) prod_q <= mul_a * mul_b;
		if (state_q == S_ACC) acc_q <= acc_q + ACW'(prod_q);
		if (state_q == S_FIN && !is_test_q && j_q != 2'd3) begin
			res_q[j_q] <= hv;
			acc_q <= (j_q == 2'd2) ? (ACW'($signed(raw_rd_q[3])) <<< 16) : '0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && (!result_valid_q || result_ready)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!result_valid_q || result_ready)) begin
			result_q.point_inside <= inside_q;
			result_q.matched_link <= match_q;
		end
	end

endmodule

`default_nettype wire

// File: hdl/chpf_checker.sv
`default_nettype none

module chpf_sva
	import chpf_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      item_valid,
	input wire logic      item_ready,
	input wire in_item_t  item,
	input wire logic      result_valid,
	input wire logic      result_ready,
	input wire out_item_t result
);

	// Stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// An outside point reports link zero
	a_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.point_inside |-> result.matched_link == 5'd0)
		else $error("matched link set for an outside point");

	// A point test keeps the block busy
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.operation == OP_TEST_POINT |=> !item_ready)
		else $error("ready right after a point test");

	// Table writes leave the block ready
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.operation == OP_WRITE_PLANE
		|| item.operation == OP_SET_COUNT || item.operation == OP_WRITE_POSE)
		|=> item_ready)
		else $error("busy after a table write");

endmodule

bind convex_hull_point_filter_top chpf_sva u_chpf_sva (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
